/* rtl/intel_hex_record_parser_defines.svh */
// ----------------------------------------------------------------------------
// Intel HEX record parser - assertion macros
// Shared clocking and reset for the concurrent checks of the parser.
// ----------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_PARSER_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define IHEX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ihex_pkg.sv */
// ----------------------------------------------------------------------------
// Intel HEX record parser - package
// Field widths, phase, result, error and record type codes, state and result types.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int AddrWidth = 16;

    // record phase
    localparam logic [2:0] PH_COLON = 3'd0;
    localparam logic [2:0] PH_LEN   = 3'd1;
    localparam logic [2:0] PH_ADDR  = 3'd2;
    localparam logic [2:0] PH_TYPE  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CSUM  = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_EOF  = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_START = 3'd1;
    localparam logic [2:0] ERR_CSUM  = 3'd2;
    localparam logic [2:0] ERR_EXT   = 3'd3;
    localparam logic [2:0] ERR_HEX   = 3'd4;

    // record types
    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;
    localparam logic [7:0] TYPE_EXT  = 8'h02;

    typedef struct packed {
        logic [2:0]           phase;
        logic                 nibble_high;
        logic [3:0]           held_nibble;
        logic [7:0]           record_length;
        logic [AddrWidth-1:0] record_address;
        logic [7:0]           record_type;
        logic [7:0]           running_sum;
        logic [7:0]           bytes_done;
        logic                 finished;
        logic                 failed;
    } state_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [AddrWidth-1:0] byte_address;
        logic [7:0]           byte_value;
        logic [2:0]           error_code;
    } result_t;

endpackage

/* rtl/ihex_step.sv */
// ----------------------------------------------------------------------------
// Intel HEX record parser - character step
// Next parser state and optional result for one character of the text.
// ----------------------------------------------------------------------------
module ihex_step
    import ihex_pkg::*;
(
    input  state_t     cur,
    input  logic [7:0] ascii_char,
    output state_t     nxt,
    output logic       res_valid,
    output result_t    res
);

    logic [4:0]           nib;
    logic [7:0]           rec_byte;
    logic [7:0]           sum_next;
    logic [7:0]           done_inc;
    logic [AddrWidth-1:0] data_addr;

    // hex digit decode, bit 4 flags a non-hex character
    always_comb
    begin
        priority if (ascii_char >= 8'h30 && ascii_char <= 8'h39)
            nib = {1'b0, ascii_char[3:0]};
        else if ((ascii_char >= 8'h41 && ascii_char <= 8'h46) ||
                 (ascii_char >= 8'h61 && ascii_char <= 8'h66))
            nib = {1'b0, ascii_char[3:0] + 4'd9};
        else
            nib = 5'h10;
    end

    assign rec_byte  = {cur.held_nibble, nib[3:0]};
    assign sum_next  = cur.running_sum + rec_byte;
    assign done_inc  = cur.bytes_done + 8'd1;
    assign data_addr = cur.record_address + {{(AddrWidth-8){1'b0}}, cur.bytes_done};

    always_comb
    begin
        nxt       = cur;
        res_valid = 1'b0;
        res       = '{kind: KIND_DATA, byte_address: '0, byte_value: 8'd0,
                      error_code: ERR_NONE};
        if (!cur.failed && !cur.finished)
        begin
            if (cur.phase == PH_COLON)
            begin
                if (ascii_char == 8'h3a)
                begin
                    nxt.phase       = PH_LEN;
                    nxt.nibble_high = 1'b0;
                    nxt.held_nibble = 4'd0;
                    nxt.running_sum = 8'd0;
                    nxt.bytes_done  = 8'd0;
                end
                else if (ascii_char != 8'h0d && ascii_char != 8'h0a)
                begin
                    nxt.failed     = 1'b1;
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERR;
                    res.error_code = ERR_START;
                end
            end
            else if (cur.phase > PH_CSUM)
            begin
                nxt.phase = PH_COLON;
            end
            else if (nib[4])
            begin
                nxt.failed     = 1'b1;
                res_valid      = 1'b1;
                res.kind       = KIND_ERR;
                res.error_code = ERR_HEX;
            end
            else if (!cur.nibble_high)
            begin
                nxt.held_nibble = nib[3:0];
                nxt.nibble_high = 1'b1;
            end
            else
            begin
                nxt.nibble_high = 1'b0;
                nxt.running_sum = sum_next;
                unique case (cur.phase)
                    PH_LEN:
                    begin
                        nxt.record_length = rec_byte;
                        nxt.bytes_done    = 8'd0;
                        nxt.phase         = PH_ADDR;
                    end
                    PH_ADDR:
                    begin
                        if (cur.bytes_done == 8'd0)
                        begin
                            nxt.record_address = {rec_byte, {(AddrWidth-8){1'b0}}};
                            nxt.bytes_done     = 8'd1;
                        end
                        else
                        begin
                            nxt.record_address = cur.record_address |
                                                 {{(AddrWidth-8){1'b0}}, rec_byte};
                            nxt.bytes_done     = 8'd0;
                            nxt.phase          = PH_TYPE;
                        end
                    end
                    PH_TYPE:
                    begin
                        nxt.record_type = rec_byte;
                        nxt.bytes_done  = 8'd0;
                        if (rec_byte == TYPE_EXT)
                        begin
                            nxt.failed     = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERR;
                            res.error_code = ERR_EXT;
                        end
                        else
                        begin
                            nxt.phase = (cur.record_length == 8'd0) ? PH_CSUM : PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        nxt.bytes_done = done_inc;
                        if (done_inc == cur.record_length)
                            nxt.phase = PH_CSUM;
                        if (cur.record_type == TYPE_DATA)
                        begin
                            res_valid        = 1'b1;
                            res.kind         = KIND_DATA;
                            res.byte_address = data_addr;
                            res.byte_value   = rec_byte;
                        end
                    end
                    default:
                    begin
                        // checksum byte closes the record
                        nxt.phase = PH_COLON;
                        priority if (sum_next != 8'd0)
                        begin
                            nxt.failed     = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERR;
                            res.error_code = ERR_CSUM;
                        end
                        else if (cur.record_type == TYPE_DATA)
                        begin
                            res_valid = 1'b1;
                            res.kind  = KIND_GOOD;
                        end
                        else if (cur.record_type == TYPE_EOF)
                        begin
                            nxt.finished = 1'b1;
                            res_valid    = 1'b1;
                            res.kind     = KIND_EOF;
                        end
                        else
                        begin
                            // skipped types close without a result
                            res_valid = 1'b0;
                        end
                    end
                endcase
            end
        end
    end

endmodule

/* rtl/intel_hex_record_parser.sv */
// ----------------------------------------------------------------------------
// Intel HEX record parser - top level
// Decodes Intel HEX text one character per transaction into data bytes,
// record-end, end-of-file and error results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: ascii_valid / ascii_stall / ascii_char, one text character
//   per transaction. Output channel: result_valid / result_stall with kind,
//   byte_address, byte_value and error_code; at most one result per character.
//   Data bytes are tentative until the record-end result (good checksum) or an
//   error result for the same record.
//   A character is taken into the input register, passes the combinational
//   character step and has its result, if any, loaded into the output register.
//   Throughput: one character per cycle while the output is not stalled,
//   through the combinational step between the input and output registers.
//   A full output register that is stalled holds the input register, which
//   then raises ascii_stall; nothing is dropped.
//   Reset clears the record state, the error and end-of-file flags and the
//   valid flags of both pipeline registers. After an error or end of file
//   every character is accepted and ignored until reset.
// ----------------------------------------------------------------------------
`include "intel_hex_record_parser_defines.svh"

module intel_hex_record_parser
    import ihex_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ascii_valid,
    output logic                 ascii_stall,
    input  logic [7:0]           ascii_char,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [1:0]           kind,
    output logic [AddrWidth-1:0] byte_address,
    output logic [7:0]           byte_value,
    output logic [2:0]           error_code
);

    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] in_char_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;
    state_t     st_reg;
    state_t     st_next;
    logic       step_valid;
    result_t    step_res;
    logic       advance;
    logic       in_take;
    logic       res_load;

    ihex_step u_step (
        .cur        (st_reg),
        .ascii_char (in_char_reg),
        .nxt        (st_next),
        .res_valid  (step_valid),
        .res        (step_res)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || !result_stall);
    assign ascii_stall = in_valid_reg && !advance;
    assign in_take     = ascii_valid && !ascii_stall;
    assign res_load    = advance && step_valid;

    assign in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? step_valid : (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_char_reg <= ascii_char;
        if (res_load)
            out_res_reg <= step_res;
    end

    assign result_valid = out_valid_reg;
    assign kind         = out_res_reg.kind;
    assign byte_address = out_res_reg.byte_address;
    assign byte_value   = out_res_reg.byte_value;
    assign error_code   = out_res_reg.error_code;

    `IHEX_ASSERT_NOW(a_silent_after_error, st_reg.failed, !res_load, "result after sticky error")
    `IHEX_ASSERT_NOW(a_silent_after_eof, st_reg.finished, !res_load, "result after end of file")
    `IHEX_ASSERT_NEXT(a_error_sticky, st_reg.failed, st_reg.failed, "error flag cleared")
    `IHEX_ASSERT_NOW(a_error_sets_flag, res_load && step_res.kind == KIND_ERR, st_next.failed,
                     "error result without error flag")
    `IHEX_ASSERT_NOW(a_phase_legal, 1'b1, st_reg.phase <= PH_CSUM, "phase out of range")

endmodule
